>>> src/dpr_pkg.sv
package dpr_pkg;

  localparam int COORD_BITS = 12;
  localparam int DISP_W     = 16;
  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int W_SHIFT    = 28;
  localparam int DISP_SCALE_SHIFT = 4;
  localparam int W_W        = 48;
  localparam int NX_W       = 33;
  localparam int NUM_W      = NX_W + W_SHIFT;
  localparam int Q_W        = 32;
  localparam int REM_W      = W_W + Q_W;
  localparam int N_CELLS    = Q_W;
  localparam int N_LANES    = 3;
  localparam int ADDR_W     = 5;

  localparam logic [DATA_W-1:0] PS_RESET = 32'h0100_0000;
  localparam logic [DATA_W-1:0] SAT_MAX  = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN  = 32'h8000_0000;

  typedef enum logic [2:0] {
    REG_X_OFFSET  = 3'd0,
    REG_Y_OFFSET  = 3'd1,
    REG_FOCAL     = 3'd2,
    REG_INV_BASE  = 3'd3,
    REG_PRIN_SHFT = 3'd4
  } dpr_reg_e;

  typedef struct packed {
    logic [DATA_W-1:0] x_offset;
    logic [DATA_W-1:0] y_offset;
    logic [DATA_W-1:0] focal_length;
    logic [DATA_W-1:0] inverse_baseline;
    logic [DATA_W-1:0] principal_shift;
  } dpr_cfg_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
    logic             neg;
    logic             ov;
  } dpr_lane_t;

  typedef struct packed {
    logic                      inf;
    logic [W_W-1:0]            dvs;
    dpr_lane_t [N_LANES-1:0]   lane;
  } dpr_cell_t;

endpackage

>>> src/dpr_front.sv
module dpr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic [dpr_pkg::COORD_BITS-1:0] column_i,
  input  logic [dpr_pkg::COORD_BITS-1:0] row_i,
  input  logic [dpr_pkg::DISP_W-1:0]   disparity_raw_i,
  input  dpr_pkg::dpr_cfg_t            cfg_i,
  output logic                         vld_o,
  output dpr_pkg::dpr_cell_t           data_o
);
  import dpr_pkg::*;

  logic                  a_vld_q;
  logic [COORD_BITS-1:0] a_x_q, a_y_q;
  logic signed [DISP_W-1:0] a_disp_q;
  logic                  b_vld_q;
  logic signed [W_W-1:0] b_w_q;
  logic signed [NX_W-1:0] b_nx_q, b_ny_q;
  logic                  c_vld_q;
  dpr_cell_t             c_data_q;

  logic signed [W_W-1:0]  prod, ps_ext, w_d;
  logic signed [NX_W-1:0] nx_d, ny_d;
  logic [W_W-1:0]         dvs;
  logic [NX_W-1:0]        mag [N_LANES];
  logic                   sgn [N_LANES];
  dpr_cell_t              c_data_d;

  // stage b: weight and numerators
  assign prod   = $signed(cfg_i.inverse_baseline) * a_disp_q;
  assign ps_ext = W_W'($signed(cfg_i.principal_shift));
  assign w_d    = prod + (ps_ext <<< DISP_SCALE_SHIFT);
  assign nx_d   = $signed({{(NX_W-COORD_BITS-FRAC_BITS){1'b0}}, a_x_q, {FRAC_BITS{1'b0}}})
                + NX_W'($signed(cfg_i.x_offset));
  assign ny_d   = $signed({{(NX_W-COORD_BITS-FRAC_BITS){1'b0}}, a_y_q, {FRAC_BITS{1'b0}}})
                + NX_W'($signed(cfg_i.y_offset));

  // stage c: magnitudes, signs and overflow check
  always_comb begin
    logic signed [NX_W-1:0] fz;
    logic [REM_W-1:0]       num;
    fz = NX_W'($signed(cfg_i.focal_length));
    dvs = b_w_q[W_W-1] ? W_W'(-b_w_q) : W_W'(b_w_q);
    mag[0] = b_nx_q[NX_W-1] ? NX_W'(-b_nx_q) : NX_W'(b_nx_q);
    mag[1] = b_ny_q[NX_W-1] ? NX_W'(-b_ny_q) : NX_W'(b_ny_q);
    mag[2] = fz[NX_W-1] ? NX_W'(-fz) : NX_W'(fz);
    sgn[0] = b_nx_q[NX_W-1];
    sgn[1] = b_ny_q[NX_W-1];
    sgn[2] = fz[NX_W-1];
    c_data_d.inf = (b_w_q == '0);
    c_data_d.dvs = dvs;
    for (int i = 0; i < N_LANES; i++) begin
      num = REM_W'({mag[i], {W_SHIFT{1'b0}}});
      c_data_d.lane[i].rem = num;
      c_data_d.lane[i].quo = '0;
      c_data_d.lane[i].neg = sgn[i] ^ b_w_q[W_W-1];
      c_data_d.lane[i].ov  = (num >= (REM_W'(dvs) << Q_W)) && (mag[i] != '0);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= vld_i && !disparity_raw_i[DISP_W-1] && (disparity_raw_i != '0);
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_x_q    <= column_i;
      a_y_q    <= row_i;
      a_disp_q <= $signed(disparity_raw_i);
      b_w_q    <= w_d;
      b_nx_q   <= nx_d;
      b_ny_q   <= ny_d;
      c_data_q <= c_data_d;
    end
  end

  assign vld_o  = c_vld_q;
  assign data_o = c_data_q;

endmodule

>>> src/dpr_cell.sv
module dpr_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  dpr_pkg::dpr_cell_t data_i,
  output logic               vld_o,
  output dpr_pkg::dpr_cell_t data_o
);
  import dpr_pkg::*;

  logic      vld_q;
  dpr_cell_t data_q, data_d;

  // one restoring step per lane, divisor aligned to the top quotient bit
  always_comb begin
    logic [REM_W-1:0] dd;
    logic             ge;
    logic [REM_W-1:0] r;
    dd = REM_W'(data_i.dvs) << (Q_W - 1);
    data_d = data_i;
    for (int i = 0; i < N_LANES; i++) begin
      ge = data_i.lane[i].rem >= dd;
      r  = ge ? data_i.lane[i].rem - dd : data_i.lane[i].rem;
      data_d.lane[i].rem = r << 1;
      data_d.lane[i].quo = {data_i.lane[i].quo[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

>>> src/disparity_to_point_reprojection.sv
// a pixel passes front stages a, b and c, then the divider cells, then the output register
// throughput: one pixel per cycle unless a finished point is held; a 32-cell restoring
// divider chain computes one quotient bit per cell for X, Y and Z in parallel
// pixels with disparity of zero or less are dropped and produce no transaction
// reset: pipeline empties, registers return to their defaults (principal_shift 1.0)
module disparity_to_point_reprojection (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [dpr_pkg::COORD_BITS-1:0] column_i,
  input  logic [dpr_pkg::COORD_BITS-1:0] row_i,
  input  logic [dpr_pkg::DISP_W-1:0]     disparity_raw_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dpr_pkg::DATA_W-1:0]     point_x_o,
  output logic [dpr_pkg::DATA_W-1:0]     point_y_o,
  output logic [dpr_pkg::DATA_W-1:0]     point_z_o,
  output logic                           at_infinity_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dpr_pkg::ADDR_W-1:0]     paddr,
  input  logic [dpr_pkg::DATA_W-1:0]     pwdata,
  output logic [dpr_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import dpr_pkg::*;

  dpr_cfg_t  cfg_q;
  dpr_reg_e  reg_idx;
  logic      en;
  logic      vld   [N_CELLS+1];
  dpr_cell_t chain [N_CELLS+1];
  logic      out_vld_q;
  logic [DATA_W-1:0] res_d [N_LANES];
  logic [DATA_W-1:0] res_q [N_LANES];
  logic      inf_q;

  // whole pipeline moves unless a finished point is held
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;
  assign pready     = 1'b1;
  assign reg_idx    = dpr_reg_e'(paddr[ADDR_W-1:2]);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_offset         <= '0;
      cfg_q.y_offset         <= '0;
      cfg_q.focal_length     <= '0;
      cfg_q.inverse_baseline <= '0;
      cfg_q.principal_shift  <= PS_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_X_OFFSET:  cfg_q.x_offset         <= pwdata;
        REG_Y_OFFSET:  cfg_q.y_offset         <= pwdata;
        REG_FOCAL:     cfg_q.focal_length     <= pwdata;
        REG_INV_BASE:  cfg_q.inverse_baseline <= pwdata;
        REG_PRIN_SHFT: cfg_q.principal_shift  <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_X_OFFSET:  prdata = cfg_q.x_offset;
      REG_Y_OFFSET:  prdata = cfg_q.y_offset;
      REG_FOCAL:     prdata = cfg_q.focal_length;
      REG_INV_BASE:  prdata = cfg_q.inverse_baseline;
      REG_PRIN_SHFT: prdata = cfg_q.principal_shift;
      default:       prdata = '0;
    endcase
  end

  // weight, numerators and operand conditioning
  dpr_front u_front (
    .clk_i,
    .rst_ni,
    .en_i            (en),
    .vld_i           (in_valid_i),
    .column_i,
    .row_i,
    .disparity_raw_i,
    .cfg_i           (cfg_q),
    .vld_o           (vld[0]),
    .data_o          (chain[0])
  );

  // divider chain
  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    dpr_cell u_cell (
      .clk_i,
      .rst_ni,
      .en_i   (en),
      .vld_i  (vld[g]),
      .data_i (chain[g]),
      .vld_o  (vld[g+1]),
      .data_o (chain[g+1])
    );
  end

  // sign and saturation; a zero numerator over zero weight gives zero
  always_comb begin
    dpr_lane_t l;
    for (int i = 0; i < N_LANES; i++) begin
      l = chain[N_CELLS].lane[i];
      if (l.ov) begin
        res_d[i] = l.neg ? SAT_MIN : SAT_MAX;
      end else if (chain[N_CELLS].inf) begin
        res_d[i] = '0;
      end else if (l.neg) begin
        res_d[i] = (l.quo > SAT_MIN) ? SAT_MIN : DATA_W'(-l.quo);
      end else begin
        res_d[i] = l.quo[Q_W-1] ? SAT_MAX : l.quo;
      end
    end
    if (chain[N_CELLS].inf) begin
      res_d[2] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld[N_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      inf_q <= chain[N_CELLS].inf;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign point_x_o     = res_q[0];
  assign point_y_o     = res_q[1];
  assign point_z_o     = res_q[2];
  assign at_infinity_o = inf_q;

  // a point at infinity carries zero depth
  a_inf_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && at_infinity_o |-> point_z_o == '0)
    else $error("depth not zero at infinity");

  // a held point freezes the last divider cell
  a_chain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> $stable(chain[N_CELLS]) && $stable(vld[N_CELLS]))
    else $error("divider chain moved under stall");

  // a dropped pixel never enters the chain
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (disparity_raw_i[DISP_W-1] || disparity_raw_i == '0)
    |=> !u_front.a_vld_q)
    else $error("invalid disparity accepted");

endmodule
